/* design/bra_pkg.sv */
// Shared types and constants for the bitmap run allocator.
// Used by bra_cell, bra_head and bitmap_run_allocator_top; depends on nothing.
package bra_pkg;

  // Bitmap geometry: the ring holds the bitmap as 32-bit words.
  localparam int MAX_BITS   = 1024;
  localparam int WORD_BITS  = 32;
  localparam int NUM_WORDS  = MAX_BITS / WORD_BITS;
  localparam int WORD_IDX_W = $clog2(NUM_WORDS);
  localparam int OFF_W      = $clog2(WORD_BITS);

  // Field widths.
  localparam int IDX_W = 10;
  localparam int LEN_W = 11;
  localparam int CFG_W = 8;

  // Configuration limits and reset value.
  localparam int          MAX_BYTES = MAX_BITS / 8;
  localparam logic [7:0]  CFG_RESET = 8'd128;

  typedef logic [WORD_BITS-1:0] word_t;

  // Request codes.
  typedef enum logic [1:0] {
    REQ_CLEAR = 2'd0,
    REQ_TEST  = 2'd1,
    REQ_WRITE = 2'd2,
    REQ_SCAN  = 2'd3
  } req_t;

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_NO_RUN = 2'd1,
    STAT_RANGE  = 2'd2
  } status_t;

  // Input transaction payload.
  typedef struct packed {
    req_t             req_type;
    logic [IDX_W-1:0] bit_index;
    logic             bit_value;
    logic [LEN_W-1:0] run_length;
  } in_t;

  // Output transaction payload.
  typedef struct packed {
    logic             bit_state;
    logic [IDX_W-1:0] start_index;
    status_t          status;
  } out_t;

  // Control from the sequencer to the head unit.
  typedef struct packed {
    logic                  init;
    logic                  step;
    logic [WORD_IDX_W-1:0] cnt;
    req_t                  op;
    logic [IDX_W-1:0]      idx;
    logic                  val;
    logic [LEN_W-1:0]      len;
    logic [LEN_W-1:0]      nbits;
  } head_ctrl_t;

  // Results gathered by the head unit over one trip around the ring.
  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] start;
    logic             tbit;
  } head_res_t;

endpackage

/* design/bitmap_run_allocator_top.sv */
// Top level of the bitmap run allocator: sequencer, ring of word cells, head unit.
// Depends on bra_pkg, bra_cell and bra_head.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------
//   in      | input     | in_valid / in_ready  | in_data  (bra_pkg::in_t)
//   out     | output    | out_valid / out_ready| out_data (bra_pkg::out_t)
//   cfg     | input     | cfg_wr_en            | cfg_wr_data (length_bytes)
//
// Test, write and scan send the 32 words once around the ring of cells, one word
// per cycle through the head unit.
// Clear all, out-of-range test and write indices and zero-length scans skip the ring.
// The output register lets a new transaction be accepted while a result waits.
// Reset (rst, synchronous) frees every bit and sets length_bytes to 128.
// A stalled output holds the finished result in the sequencer until it can move on.
module bitmap_run_allocator_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  bra_pkg::in_t              in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output bra_pkg::out_t             out_data,
  input  logic                      cfg_wr_en,
  input  logic [bra_pkg::CFG_W-1:0] cfg_wr_data
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_ROT  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  localparam logic [bra_pkg::WORD_IDX_W-1:0] LAST =
    bra_pkg::WORD_IDX_W'(bra_pkg::NUM_WORDS - 1);

  state_t                          state;
  logic [bra_pkg::WORD_IDX_W-1:0]  cnt;
  bra_pkg::in_t                    req_q;
  logic [bra_pkg::CFG_W-1:0]       len_bytes;
  bra_pkg::out_t                   res_q;
  logic                            rotated;

  logic                      accept;
  logic [bra_pkg::CFG_W-1:0] eff_bytes;
  logic [bra_pkg::LEN_W-1:0] nbits;
  logic                      in_range;
  logic                      needs_rot;
  bra_pkg::out_t             imm_res;
  bra_pkg::out_t             result;
  logic                      out_free;
  bra_pkg::head_ctrl_t       ctrl;
  bra_pkg::head_res_t        hres;
  bra_pkg::word_t            tail;
  bra_pkg::word_t            ring [bra_pkg::NUM_WORDS];

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      len_bytes <= bra_pkg::CFG_RESET;
    end else if (cfg_wr_en) begin
      len_bytes <= cfg_wr_data;
    end
  end

  // Active bit count, limited to the storage size.
  assign eff_bytes = (len_bytes > bra_pkg::CFG_W'(bra_pkg::MAX_BYTES)) ?
                     bra_pkg::CFG_W'(bra_pkg::MAX_BYTES) : len_bytes;
  assign nbits     = bra_pkg::LEN_W'(eff_bytes) << 3;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign in_range = (bra_pkg::LEN_W'(in_data.bit_index) < nbits);
  assign out_free = !out_valid || out_ready;

  // Decide at accept time whether the transaction needs a trip around the ring.
  always_comb begin
    imm_res   = '{bit_state: 1'b0, start_index: '0, status: bra_pkg::STAT_OK};
    needs_rot = 1'b0;
    case (in_data.req_type)
      bra_pkg::REQ_CLEAR: begin
        needs_rot = 1'b0;
      end
      bra_pkg::REQ_TEST, bra_pkg::REQ_WRITE: begin
        if (in_range) begin
          needs_rot = 1'b1;
        end else begin
          imm_res.status = bra_pkg::STAT_RANGE;
        end
      end
      bra_pkg::REQ_SCAN: begin
        needs_rot = (in_data.run_length != '0);
      end
      default: begin
        needs_rot = 1'b0;
      end
    endcase
  end

  // Result: from the head unit after a trip around the ring, else the immediate result.
  always_comb begin
    result = res_q;
    if (rotated) begin
      result = '{bit_state: 1'b0, start_index: '0, status: bra_pkg::STAT_OK};
      case (req_q.req_type)
        bra_pkg::REQ_TEST: begin
          result.bit_state = hres.tbit;
        end
        bra_pkg::REQ_SCAN: begin
          if (hres.found) begin
            result.start_index = hres.start;
          end else begin
            result.status = bra_pkg::STAT_NO_RUN;
          end
        end
        default: begin
          result.status = bra_pkg::STAT_OK;
        end
      endcase
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      cnt     <= '0;
      rotated <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            cnt     <= '0;
            rotated <= needs_rot;
            state   <= needs_rot ? S_ROT : S_DONE;
          end
        end
        S_ROT: begin
          cnt <= cnt + 1'b1;
          if (cnt == LAST) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Latched request and immediate result.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= in_data;
      res_q <= imm_res;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      out_data <= result;
    end
  end

  // Head unit control.
  assign ctrl.init  = accept;
  assign ctrl.step  = (state == S_ROT);
  assign ctrl.cnt   = cnt;
  assign ctrl.op    = req_q.req_type;
  assign ctrl.idx   = req_q.bit_index;
  assign ctrl.val   = req_q.bit_value;
  assign ctrl.len   = req_q.run_length;
  assign ctrl.nbits = nbits;

  bra_head u_head (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ctrl),
    .head (ring[0]),
    .tail (tail),
    .res  (hres)
  );

  // Ring of cells: each takes its upper neighbor's word, the last takes the head output.
  for (genvar k = 0; k < bra_pkg::NUM_WORDS; k++) begin : g_cell
    bra_pkg::word_t d;
    if (k == bra_pkg::NUM_WORDS - 1) begin : g_last
      assign d = tail;
    end else begin : g_mid
      assign d = ring[k+1];
    end
    bra_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (state == S_ROT),
      .clear (accept && in_data.req_type == bra_pkg::REQ_CLEAR),
      .d     (d),
      .q     (ring[k])
    );
  end

  // A trip around the ring always ends after the last word.
  a_trip_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROT && cnt == LAST) |=> (state == S_DONE))
    else $error("ring trip did not end on the last word");

  // The bitmap holds still while a result is handed over.
  a_ring_still: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |=> $stable(ring[0]))
    else $error("ring moved outside a trip");

  // A finished result reaches the output register when it is free.
  a_result_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_free) |=> (out_valid && state == S_IDLE))
    else $error("finished result not delivered");

endmodule

/* design/bra_cell.sv */
// One cell of the bitmap ring: holds one 32-bit word of the bitmap.
// Depends on bra_pkg for the word type.
module bra_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          shift,
  input  logic          clear,
  input  bra_pkg::word_t d,
  output bra_pkg::word_t q
);

  // Reset and clear-all free every bit; a shift takes the neighbor's word.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      q <= '0;
    end else if (shift) begin
      q <= d;
    end
  end

endmodule

/* design/bra_head.sv */
// Head unit of the bitmap ring: edits, tests and scans the word leaving cell 0.
// Depends on bra_pkg for the word, request and control types.
module bra_head (
  input  logic                clk,
  input  logic                rst,
  input  bra_pkg::head_ctrl_t ctrl,
  input  bra_pkg::word_t      head,
  output bra_pkg::word_t      tail,
  output bra_pkg::head_res_t  res
);

  localparam int GW_W = bra_pkg::LEN_W - bra_pkg::OFF_W;

  logic [bra_pkg::LEN_W-1:0] carry;
  logic                      found;
  logic [bra_pkg::IDX_W-1:0] start_q;
  logic                      tbit;

  logic                        word_hit;
  logic [bra_pkg::OFF_W-1:0]   off;
  bra_pkg::word_t              valid;
  bra_pkg::word_t              view;
  logic [bra_pkg::LEN_W-1:0]   run [bra_pkg::WORD_BITS];
  bra_pkg::word_t              hit;
  logic [bra_pkg::OFF_W-1:0]   pick;
  logic [bra_pkg::LEN_W-1:0]   carry_next;
  logic [bra_pkg::LEN_W:0]     start_w;
  logic [GW_W-1:0]             full_words;
  logic [GW_W-1:0]             cnt_ext;

  // Position of the highest set bit of a word.
  function automatic logic [bra_pkg::OFF_W-1:0] msb_pos(input bra_pkg::word_t m);
    logic [bra_pkg::OFF_W-1:0] p;
    p = '0;
    for (int i = 0; i < bra_pkg::WORD_BITS; i++) begin
      if (m[i]) begin
        p = bra_pkg::OFF_W'(i);
      end
    end
    return p;
  endfunction

  assign word_hit = (ctrl.cnt == ctrl.idx[bra_pkg::IDX_W-1:bra_pkg::OFF_W]);
  assign off      = ctrl.idx[bra_pkg::OFF_W-1:0];

  // A write replaces one bit as its word passes the head.
  always_comb begin
    tail = head;
    if (ctrl.op == bra_pkg::REQ_WRITE && word_hit) begin
      tail[off] = ctrl.val;
    end
  end

  // Bits at or beyond the active length look used to the scan.
  assign full_words = ctrl.nbits[bra_pkg::LEN_W-1:bra_pkg::OFF_W];
  assign cnt_ext    = GW_W'(ctrl.cnt);

  always_comb begin
    for (int j = 0; j < bra_pkg::WORD_BITS; j++) begin
      if (cnt_ext < full_words) begin
        valid[j] = 1'b1;
      end else if (cnt_ext == full_words) begin
        valid[j] = (bra_pkg::OFF_W'(j) < ctrl.nbits[bra_pkg::OFF_W-1:0]);
      end else begin
        valid[j] = 1'b0;
      end
    end
  end

  assign view = head | ~valid;

  // Length of the free run that ends at each bit, counting the carried run.
  always_comb begin
    bra_pkg::word_t mk;
    for (int j = 0; j < bra_pkg::WORD_BITS; j++) begin
      for (int k = 0; k < bra_pkg::WORD_BITS; k++) begin
        mk[k] = view[k] && (k <= j);
      end
      if (mk == '0) begin
        run[j] = carry + bra_pkg::LEN_W'(j + 1);
      end else begin
        run[j] = bra_pkg::LEN_W'(j) - bra_pkg::LEN_W'(msb_pos(mk));
      end
      hit[j] = (run[j] >= ctrl.len);
    end
  end

  // Lowest bit at which the run reaches the requested length.
  always_comb begin
    pick = '0;
    for (int j = bra_pkg::WORD_BITS - 1; j >= 0; j--) begin
      if (hit[j]) begin
        pick = bra_pkg::OFF_W'(j);
      end
    end
  end

  assign carry_next = run[bra_pkg::WORD_BITS-1];
  assign start_w    = (bra_pkg::LEN_W + 1)'({ctrl.cnt, pick}) + (bra_pkg::LEN_W + 1)'(1)
                      - (bra_pkg::LEN_W + 1)'(ctrl.len);

  // Scan and test state, restarted with every accepted transaction.
  always_ff @(posedge clk) begin
    if (rst || ctrl.init) begin
      carry   <= '0;
      found   <= 1'b0;
      start_q <= '0;
      tbit    <= 1'b0;
    end else if (ctrl.step) begin
      if (ctrl.op == bra_pkg::REQ_SCAN && !found) begin
        carry <= carry_next;
        if (hit != '0) begin
          found   <= 1'b1;
          start_q <= start_w[bra_pkg::IDX_W-1:0];
        end
      end
      if (ctrl.op == bra_pkg::REQ_TEST && word_hit) begin
        tbit <= head[off];
      end
    end
  end

  assign res.found = found;
  assign res.start = start_q;
  assign res.tbit  = tbit;

  // Once a run is found the scan keeps that answer for the rest of the trip.
  a_found_sticky: assert property (@(posedge clk) disable iff (rst)
    (ctrl.step && !ctrl.init && found) |=> (found && $stable(start_q)))
    else $error("found run lost during scan");

endmodule
